[rtl/mmts_pkg.sv]
// ----------------------------------------------------------------------------
// mmts_pkg
// Shared types and constants of the Max-Min task scheduler.
// ----------------------------------------------------------------------------
package mmts_pkg;

	localparam int MAX_MACHINES_DEF = 8;
	localparam int MAX_TASKS_DEF    = 16;
	localparam int TIME_BITS_DEF    = 16;

	localparam int FIN_BITS = 20;
	localparam logic [FIN_BITS-1:0] FIN_MAX = '1;

	localparam int CFG_IDX_BITS  = 4;
	localparam int CFG_DATA_BITS = 8;

	localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_MACHINES = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_TASKS    = CFG_IDX_BITS'(1);

	localparam logic [3:0] NUM_MACHINES_RST = 4'd8;
	localparam logic [4:0] NUM_TASKS_RST    = 5'd16;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RUN  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic        mode;
		logic [2:0]  machine_index;
		logic [3:0]  task_index;
		logic [15:0] exec_time;
	} req_t;

	typedef struct packed {
		logic [3:0]          task_res;
		logic [2:0]          machine;
		logic [15:0]         task_time;
		logic [FIN_BITS-1:0] finish_time;
		logic [FIN_BITS-1:0] makespan;
		logic                last;
	} result_t;

endpackage

[rtl/max_min_task_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// max_min_task_scheduler_unit
// Max-Min list scheduler over a loaded execution-time matrix.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. A load request
//   (mode 0) writes one matrix entry in that cycle and raises no busy; entries
//   outside the matrix are dropped. A run request (mode 1) schedules every task
//   in use and raises busy until the last result has been produced.
//   Results appear on result with result_valid high for one cycle each, one per
//   task, with last set on the final one. The receiver cannot stall them.
//   Configuration writes (cfg_index 0: machines, 1: tasks) are taken while
//   cfg_ready is high, which is whenever the block is idle.
// Timing:
//   One shared add/compare unit walks the matrix one entry a cycle, fed from a
//   registered read of the matrix memory. Each scheduled task takes a scan over
//   every matrix entry in use, a drain of the compare pipeline and a step to
//   choose it; busy stays high until the last task has been chosen. Each result
//   follows its choice in the next cycle; the last one comes in the first cycle
//   with busy low.
// Reset:
//   arst_n clears the control state and sets 8 machines and 16 tasks; the
//   matrix keeps no reset value and must be loaded before a run reads it.
// ----------------------------------------------------------------------------
module max_min_task_scheduler_unit #(
	parameter int MAX_MACHINES = mmts_pkg::MAX_MACHINES_DEF,
	parameter int MAX_TASKS    = mmts_pkg::MAX_TASKS_DEF,
	parameter int TIME_BITS    = mmts_pkg::TIME_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  mmts_pkg::req_t                        req,
	output logic                                  result_valid,
	output mmts_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mmts_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mmts_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int MW    = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam int TW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int DEPTH = MAX_MACHINES * MAX_TASKS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FB    = mmts_pkg::FIN_BITS;
	localparam int SW    = ((TIME_BITS > FB) ? TIME_BITS : FB) + 1;

	mmts_pkg::state_t state_q, state_d;

	logic [3:0]           num_machines_q;
	logic [4:0]           num_tasks_q;
	logic [MW-1:0]        m_last;
	logic [TW-1:0]        t_last;

	logic [TIME_BITS-1:0] mem [DEPTH];
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic                 wr_en;

	logic [MW-1:0]        i_q;
	logic [TW-1:0]        j_q;
	logic [TW-1:0]        k_q;
	logic [MAX_TASKS-1:0] done_q;
	logic [FB-1:0]        ready_q [MAX_MACHINES];
	logic [FB-1:0]        span_q;

	logic                 run_go;
	logic                 issue;
	logic                 scan_end;

	logic                 v_s1;
	logic                 first_s1;
	logic                 lasti_s1;
	logic [MW-1:0]        i_s1;
	logic [TW-1:0]        j_s1;
	logic [TIME_BITS-1:0] rd_s1;

	logic [FB-1:0]        mfin_q;
	logic [MW-1:0]        mm_q;
	logic [TIME_BITS-1:0] mt_q;

	logic [SW-1:0]        sum;
	logic [FB-1:0]        f;
	logic                 take;
	logic [FB-1:0]        cand_fin;
	logic [MW-1:0]        cand_mach;
	logic [TIME_BITS-1:0] cand_time;

	logic                 v_s2;
	logic [FB-1:0]        fin_s2;
	logic [MW-1:0]        mach_s2;
	logic [TW-1:0]        task_s2;
	logic [TIME_BITS-1:0] time_s2;

	logic                 have_q;
	logic [FB-1:0]        best_fin_q;
	logic [MW-1:0]        best_mach_q;
	logic [TW-1:0]        best_task_q;
	logic [TIME_BITS-1:0] best_time_q;
	logic [FB-1:0]        span_new;

	logic                 result_valid_q;
	mmts_pkg::result_t    result_q;

	always_comb begin
		if (num_machines_q == '0) begin
			m_last = '0;
		end else if (int'(num_machines_q) >= MAX_MACHINES) begin
			m_last = MW'(MAX_MACHINES - 1);
		end else begin
			m_last = MW'(num_machines_q - 4'd1);
		end
		if (num_tasks_q == '0) begin
			t_last = '0;
		end else if (int'(num_tasks_q) >= MAX_TASKS) begin
			t_last = TW'(MAX_TASKS - 1);
		end else begin
			t_last = TW'(num_tasks_q - 5'd1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmts_pkg::ST_IDLE: begin
				if (start && req.mode == mmts_pkg::MODE_RUN) state_d = mmts_pkg::ST_SCAN;
			end
			mmts_pkg::ST_SCAN: begin
				if (scan_end) state_d = mmts_pkg::ST_DRAIN;
			end
			mmts_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) state_d = mmts_pkg::ST_EMIT;
			end
			mmts_pkg::ST_EMIT: begin
				state_d = (k_q == t_last) ? mmts_pkg::ST_IDLE : mmts_pkg::ST_SCAN;
			end
			default: state_d = mmts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != mmts_pkg::ST_IDLE);
		cfg_ready = (state_q == mmts_pkg::ST_IDLE);
		run_go    = (state_q == mmts_pkg::ST_IDLE) && start && req.mode == mmts_pkg::MODE_RUN;
		wr_en     = (state_q == mmts_pkg::ST_IDLE) && start && req.mode == mmts_pkg::MODE_LOAD
			&& int'(req.machine_index) < MAX_MACHINES && int'(req.task_index) < MAX_TASKS;
		issue     = (state_q == mmts_pkg::ST_SCAN) && !done_q[j_q];
		scan_end  = (state_q == mmts_pkg::ST_SCAN) && i_q == m_last && j_q == t_last;
	end

	assign wr_addr = AW'(int'(req.machine_index) * MAX_TASKS + int'(req.task_index));
	assign rd_addr = AW'(int'(i_q) * MAX_TASKS + int'(j_q));

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= TIME_BITS'(req.exec_time);
		rd_s1 <= mem[rd_addr];
	end

	always_comb begin
		sum       = SW'(ready_q[i_s1]) + SW'(rd_s1);
		f         = (sum > SW'(mmts_pkg::FIN_MAX)) ? mmts_pkg::FIN_MAX : FB'(sum);
		take      = first_s1 || f < mfin_q;
		cand_fin  = take ? f : mfin_q;
		cand_mach = take ? i_s1 : mm_q;
		cand_time = take ? rd_s1 : mt_q;
		span_new  = (best_fin_q > span_q) ? best_fin_q : span_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mmts_pkg::ST_IDLE;
			num_machines_q <= mmts_pkg::NUM_MACHINES_RST;
			num_tasks_q    <= mmts_pkg::NUM_TASKS_RST;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			done_q         <= '0;
			span_q         <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			have_q         <= 1'b0;
			result_valid_q <= 1'b0;
			for (int m = 0; m < MAX_MACHINES; m++) ready_q[m] <= '0;
		end else begin
			state_q        <= state_d;
			v_s1           <= issue;
			v_s2           <= v_s1 && lasti_s1;
			result_valid_q <= (state_q == mmts_pkg::ST_EMIT);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mmts_pkg::CFG_NUM_MACHINES) num_machines_q <= cfg_data[3:0];
				if (cfg_index == mmts_pkg::CFG_NUM_TASKS) num_tasks_q <= cfg_data[4:0];
			end
			if (run_go) begin
				i_q    <= '0;
				j_q    <= '0;
				k_q    <= '0;
				done_q <= '0;
				span_q <= '0;
				have_q <= 1'b0;
				for (int m = 0; m < MAX_MACHINES; m++) ready_q[m] <= '0;
			end
			if (state_q == mmts_pkg::ST_SCAN) begin
				if (i_q == m_last) begin
					i_q <= '0;
					j_q <= j_q + 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			if (v_s2 && (!have_q || fin_s2 > best_fin_q)) have_q <= 1'b1;
			if (state_q == mmts_pkg::ST_EMIT) begin
				done_q[best_task_q]  <= 1'b1;
				ready_q[best_mach_q] <= best_fin_q;
				span_q               <= span_new;
				k_q                  <= k_q + 1'b1;
				have_q               <= 1'b0;
				i_q                  <= '0;
				j_q                  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (i_q == '0);
		lasti_s1 <= (i_q == m_last);
		i_s1     <= i_q;
		j_s1     <= j_q;
		if (v_s1) begin
			mfin_q <= cand_fin;
			mm_q   <= cand_mach;
			mt_q   <= cand_time;
		end
		fin_s2  <= cand_fin;
		mach_s2 <= cand_mach;
		time_s2 <= cand_time;
		task_s2 <= j_s1;
		if (v_s2 && (!have_q || fin_s2 > best_fin_q)) begin
			best_fin_q  <= fin_s2;
			best_mach_q <= mach_s2;
			best_task_q <= task_s2;
			best_time_q <= time_s2;
		end
		if (state_q == mmts_pkg::ST_EMIT) begin
			result_q.task_res    <= 4'(best_task_q);
			result_q.machine     <= 3'(best_mach_q);
			result_q.task_time   <= 16'(best_time_q);
			result_q.finish_time <= best_fin_q;
			result_q.makespan    <= span_new;
			result_q.last        <= (k_q == t_last);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/mmts_checker.sv]
// ----------------------------------------------------------------------------
// mmts_checker
// Port-level checks of the Max-Min task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mmts_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input mmts_pkg::req_t    req,
	input logic              result_valid,
	input mmts_pkg::result_t result
);

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.mode == mmts_pkg::MODE_RUN |=> busy)
		else $error("run request did not raise busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("block idle before the last result");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("block still busy at the last result");

	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.makespan >= result.finish_time)
		else $error("makespan below finish time");

endmodule

bind max_min_task_scheduler_unit mmts_checker u_mmts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req          (req),
	.result_valid (result_valid),
	.result       (result)
);
